@@ sv/tfrce_pkg.sv @@
package tfrce_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned ADDR_W = 2;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned CNT_W  = 3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PRINT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

  // instruction classes, top two bits give the alu group
  localparam logic [1:0] GRP_ALU   = 2'b10;
  localparam logic [5:0] OP_LOAD   = 6'd48;
  localparam logic [5:0] OP_PRINT  = 6'd49;

  // target of the immediate move
  localparam logic [ADDR_W-1:0] REG_MOVE = 2'd3;

  // alu operation in bits 5..4
  localparam logic [1:0] ALU_ADD = 2'd0;
  localparam logic [1:0] ALU_SUB = 2'd1;
  localparam logic [1:0] ALU_MUL = 2'd2;
  localparam logic [1:0] ALU_DIV = 2'd3;

  // last divider step
  localparam logic [CNT_W-1:0] DIV_LAST = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic accept;    // latch request and read operands
    logic exec;      // execute latched instruction
    logic div_step;  // one restoring divide step
    logic out_load;  // move pending result to output register
  } ctl_cmd_t;

  typedef struct packed {
    logic div_start; // latched instruction needs the divider
    logic div_done;  // divider on its last step
    logic out_free;  // output register can take a result
  } dp_sts_t;

endpackage

@@ sv/tfrce_ctrl.sv @@
module tfrce_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  tfrce_pkg::dp_sts_t  sts,
  output tfrce_pkg::ctl_cmd_t cmd,
  output logic                busy
);

  tfrce_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tfrce_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tfrce_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = tfrce_pkg::ST_EXEC;
        end
      end
      tfrce_pkg::ST_EXEC: begin
        if (sts.div_start) begin
          state_nxt = tfrce_pkg::ST_DIV;
        end else begin
          state_nxt = tfrce_pkg::ST_EMIT;
        end
      end
      tfrce_pkg::ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = tfrce_pkg::ST_EMIT;
        end
      end
      tfrce_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = tfrce_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tfrce_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      tfrce_pkg::ST_IDLE: begin
        busy       = 1'b0;
        cmd.accept = in_valid;
      end
      tfrce_pkg::ST_EXEC: cmd.exec = 1'b1;
      tfrce_pkg::ST_DIV:  cmd.div_step = 1'b1;
      tfrce_pkg::ST_EMIT: cmd.out_load = sts.out_free;
      default: busy = 1'b1;
    endcase
  end

endmodule

@@ sv/tfrce_dp.sv @@
module tfrce_dp (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  tfrce_pkg::ctl_cmd_t                      cmd,
  output tfrce_pkg::dp_sts_t                       sts,
  input  logic [tfrce_pkg::DATA_W-1:0]             in_instruction,
  input  logic [tfrce_pkg::DATA_W-1:0]             in_input_value,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic [tfrce_pkg::KIND_W-1:0]             out_kind,
  output logic [tfrce_pkg::DATA_W-1:0]             out_printed_value
);

  localparam int unsigned DW = tfrce_pkg::DATA_W;
  localparam int unsigned AW = tfrce_pkg::ADDR_W;

  logic [DW-1:0] rf_r [4];

  logic [DW-1:0] ins_r, inval_r, opa_r, opb_r;
  logic          halted_r;
  logic [tfrce_pkg::KIND_W-1:0] res_kind_r;
  logic [DW-1:0] res_val_r;

  logic [DW-1:0] quo_r, rem_r;
  logic [tfrce_pkg::CNT_W-1:0] cnt_r;

  logic out_valid_r;
  logic [tfrce_pkg::KIND_W-1:0] out_kind_r;
  logic [DW-1:0] out_val_r;

  // decode of the latched instruction
  logic          is_move, is_alu, is_load, is_print, is_err;
  logic [1:0]    alu_op;
  logic [AW-1:0] dst_a, src_a;
  logic [DW-1:0] alu_res;
  logic [2*DW-1:0] prod;

  // register file write port
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;

  // divider step
  logic [DW:0]   trial;
  logic [DW-1:0] quo_nxt, rem_nxt;

  always_comb begin
    is_move  = ~ins_r[DW-1];
    is_alu   = (ins_r[DW-1 -: 2] == tfrce_pkg::GRP_ALU);
    is_load  = (ins_r[DW-1:2] == tfrce_pkg::OP_LOAD);
    is_print = (ins_r[DW-1:2] == tfrce_pkg::OP_PRINT);
    alu_op   = ins_r[5:4];
    dst_a    = ins_r[3:2];
    src_a    = ins_r[1:0];
    is_err   = ~(is_move | is_alu | is_load | is_print) |
               (is_alu & (alu_op == tfrce_pkg::ALU_DIV) & (opb_r == '0));
    prod     = opa_r * opb_r;
    case (alu_op)
      tfrce_pkg::ALU_ADD: alu_res = opa_r + opb_r;
      tfrce_pkg::ALU_SUB: alu_res = opa_r - opb_r;
      tfrce_pkg::ALU_MUL: alu_res = prod[DW-1:0];
      default:            alu_res = '0;
    endcase
  end

  always_comb begin
    trial = {rem_r, quo_r[DW-1]} - {1'b0, opb_r};
    if (!trial[DW]) begin
      rem_nxt = trial[DW-1:0];
      quo_nxt = {quo_r[DW-2:0], 1'b1};
    end else begin
      rem_nxt = {rem_r[DW-2:0], quo_r[DW-1]};
      quo_nxt = {quo_r[DW-2:0], 1'b0};
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = dst_a;
    wr_data = alu_res;
    if (cmd.exec && !halted_r && !is_err) begin
      if (is_move) begin
        wr_en   = 1'b1;
        wr_addr = tfrce_pkg::REG_MOVE;
        wr_data = {1'b0, ins_r[DW-2:0]};
      end else if (is_alu && alu_op != tfrce_pkg::ALU_DIV) begin
        wr_en = 1'b1;
      end else if (is_load) begin
        wr_en   = 1'b1;
        wr_addr = src_a;
        wr_data = inval_r;
      end
    end else if (cmd.div_step && cnt_r == tfrce_pkg::DIV_LAST) begin
      wr_en   = 1'b1;
      wr_data = quo_nxt;
    end
  end

  // register file: one write, two registered reads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        rf_r[i] <= '0;
      end
    end else if (wr_en) begin
      rf_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ins_r   <= in_instruction;
      inval_r <= in_input_value;
      opa_r   <= rf_r[in_instruction[3:2]];
      opb_r   <= rf_r[in_instruction[1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halted_r <= 1'b0;
    end else if (cmd.exec && is_err) begin
      halted_r <= 1'b1;
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (halted_r) begin
        res_kind_r <= tfrce_pkg::KIND_NONE;
        res_val_r  <= '0;
      end else if (is_err) begin
        res_kind_r <= tfrce_pkg::KIND_ERROR;
        res_val_r  <= '0;
      end else if (is_print) begin
        res_kind_r <= tfrce_pkg::KIND_PRINT;
        res_val_r  <= opb_r;
      end else begin
        res_kind_r <= tfrce_pkg::KIND_NONE;
        res_val_r  <= '0;
      end
    end
  end

  // restoring divider
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      quo_r <= opa_r;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind_r <= res_kind_r;
      out_val_r  <= res_val_r;
    end
  end

  assign sts.div_start = ~halted_r & ~is_err & is_alu & (alu_op == tfrce_pkg::ALU_DIV);
  assign sts.div_done  = (cnt_r == tfrce_pkg::DIV_LAST);
  assign sts.out_free  = ~out_valid_r | ~out_stall;

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_printed_value = out_val_r;

endmodule

@@ sv/tiny_four_register_cpu_execute.sv @@
// a taken request goes through exec, then emit, which loads the result into the
//   output register once it is free; a divide runs the 8 steps of the restoring
//   divider between exec and emit; requests are taken one at a time
// the result sits in an output register, so a new request is taken while it waits
// reset (rst_n low, synchronous): registers cleared to zero, halt flag cleared,
//   no result pending
module tiny_four_register_cpu_execute (
  input  logic       clk,
  input  logic       rst_n,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_instruction,
  input  logic [7:0] in_input_value,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_printed_value
);

  // command and status between the sequencer and the datapath
  tfrce_pkg::ctl_cmd_t cmd;
  tfrce_pkg::dp_sts_t  sts;
  logic                busy;

  // sequencer: idle -> exec -> (div x8) -> emit -> idle
  tfrce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  // register file, decode, alu, divider and output register
  tfrce_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_instruction    (in_instruction),
    .in_input_value    (in_input_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_printed_value (out_printed_value)
  );

  // no request is taken while reset is held or an instruction is in flight
  assign in_stall = ~rst_n | busy;

endmodule

@@ sv/tfrce_chk.sv @@
module tfrce_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_kind,
  input logic [7:0] out_printed_value
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_printed_value))
    else $error("stalled result changed");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == tfrce_pkg::KIND_NONE || out_kind == tfrce_pkg::KIND_PRINT ||
                   out_kind == tfrce_pkg::KIND_ERROR))
    else $error("illegal result kind");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != tfrce_pkg::KIND_PRINT |-> out_printed_value == 8'd0)
    else $error("value on a non-print result");

  // one request at a time
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while busy");

endmodule

bind tiny_four_register_cpu_execute tfrce_chk u_tfrce_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_kind          (out_kind),
  .out_printed_value (out_printed_value)
);

@@ bench/tiny_four_register_cpu_execute_tb.sv @@
`timescale 1ns / 1ps

module tiny_four_register_cpu_execute_tb;

  // run limits
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 30;   // leave margin after the slowest request, a divide
  localparam int HOLD_CYCLES  = 120;  // long receiver hold-off
  localparam int RANDOM_ITEMS = 540;

  typedef struct packed {
    logic [tfrce_pkg::KIND_W-1:0] kind;
    logic [tfrce_pkg::DATA_W-1:0] value;
  } cpu_result_t;

  // clock and reset, every input known from time zero
  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_instruction = 8'h00;
  logic [7:0] in_input_value = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_printed_value;

  // predicted processor state
  logic [tfrce_pkg::DATA_W-1:0] reg_file [4] = '{default: 8'h00};
  logic              halted = 1'b0;

  // results still owed by the block, oldest first
  cpu_result_t pending_results[$];

  int  mismatches = 0;
  int  cycle_count = 0;
  int  stall_left = 0;
  int  roll;
  logic no_idle = 1'b0;   // while set, the sender leaves no gaps and the receiver adds no random stalls
  logic hold_on = 1'b0;   // receiver hold-off, set by the pressure test

  tiny_four_register_cpu_execute dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_instruction    (in_instruction),
    .in_input_value    (in_input_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_printed_value (out_printed_value)
  );

  always #10 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // execute one instruction on the predicted state, return the result it gives
  function automatic cpu_result_t execute_instruction(input logic [7:0] instr,
                                                      input logic [7:0] value);
    cpu_result_t                  res;
    logic [1:0]                   dst;
    logic [1:0]                   src;
    logic [tfrce_pkg::DATA_W-1:0] a;
    logic [tfrce_pkg::DATA_W-1:0] b;
    logic [15:0]                  wide;
    res.kind  = tfrce_pkg::KIND_NONE;
    res.value = 8'h00;
    dst = instr[3:2];
    src = instr[1:0];
    a   = reg_file[dst];
    b   = reg_file[src];
    if (halted) begin
      // halted block: nothing runs, quiet result
    end else if (!instr[7]) begin
      reg_file[tfrce_pkg::REG_MOVE] = {1'b0, instr[6:0]};
    end else if (instr[7:6] == tfrce_pkg::GRP_ALU) begin
      case (instr[5:4])
        tfrce_pkg::ALU_ADD: reg_file[dst] = a + b;
        tfrce_pkg::ALU_SUB: reg_file[dst] = a - b;
        tfrce_pkg::ALU_MUL: begin
          wide = a * b;
          reg_file[dst] = wide[7:0];
        end
        default: begin
          if (b == 8'h00) begin
            // divide by zero halts, registers untouched
            halted   = 1'b1;
            res.kind = tfrce_pkg::KIND_ERROR;
          end else begin
            reg_file[dst] = a / b;
          end
        end
      endcase
    end else if (instr[7:2] == tfrce_pkg::OP_LOAD) begin
      reg_file[src] = value;
    end else if (instr[7:2] == tfrce_pkg::OP_PRINT) begin
      res.kind  = tfrce_pkg::KIND_PRINT;
      res.value = b;
    end else begin
      // undefined opcode
      halted   = 1'b1;
      res.kind = tfrce_pkg::KIND_ERROR;
    end
    return res;
  endfunction

  function automatic logic [7:0] alu_instr(input logic [1:0] op, input logic [1:0] dst,
                                           input logic [1:0] src);
    return {tfrce_pkg::GRP_ALU, op, dst, src};
  endfunction

  // sender gap: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // well-formed instruction that keeps the block running
  function automatic logic [7:0] pick_instruction();
    int         sel;
    logic [1:0] op;
    logic [1:0] dst;
    logic [1:0] src;
    sel = $urandom_range(0, 99);
    op  = 2'($urandom);
    dst = 2'($urandom);
    src = 2'($urandom);
    if (sel < 20) return {1'b0, 7'($urandom)};
    if (sel < 40) return {tfrce_pkg::OP_LOAD, src};
    if (sel < 58) return {tfrce_pkg::OP_PRINT, src};
    // never divide by a zero register here, halting is tested on its own
    if (op == tfrce_pkg::ALU_DIV && reg_file[src] == 8'h00) op = tfrce_pkg::ALU_ADD;
    return alu_instr(op, dst, src);
  endfunction

  // load data leaning on the extremes
  function automatic logic [7:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'h00;
    if (r < 30) return 8'hFF;
    return 8'($urandom);
  endfunction

  // offer one request, hold it until taken, then predict its result
  // called right after a rising edge
  task automatic send_request(input logic [7:0] instr, input logic [7:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_instruction <= instr;
    in_input_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(execute_instruction(instr, value));
  endtask

  // receiver: check taken results, then decide next cycle's stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d value %0d",
                                    out_kind, out_printed_value));
        end else begin
          if (out_kind !== pending_results[0].kind)
            report_mismatch($sformatf("kind got %0d want %0d", out_kind,
                                      pending_results[0].kind));
          if (out_printed_value !== pending_results[0].value)
            report_mismatch($sformatf("printed value got %0d want %0d",
                                      out_printed_value, pending_results[0].value));
          void'(pending_results.pop_front());
        end
      end
      if (hold_on) begin
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (no_idle) begin
        out_stall <= 1'b0;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
          out_stall <= 1'b0;
        end else if (roll < 94) begin
          out_stall  <= 1'b1;
          stall_left <= $urandom_range(0, 2);
        end else begin
          out_stall  <= 1'b1;
          stall_left <= $urandom_range(8, 40);
        end
      end
    end
  end

  // extremes of the data path and every operation, no halting
  task automatic test_directed();
    send_request({tfrce_pkg::OP_LOAD, 2'd0}, 8'hFF);
    send_request({tfrce_pkg::OP_LOAD, 2'd1}, 8'h01);
    send_request(alu_instr(tfrce_pkg::ALU_ADD, 2'd0, 2'd1), 8'($urandom));  // 255 + 1 wraps
    send_request({tfrce_pkg::OP_PRINT, 2'd0}, 8'($urandom));
    send_request({tfrce_pkg::OP_LOAD, 2'd2}, 8'h00);
    send_request(alu_instr(tfrce_pkg::ALU_SUB, 2'd2, 2'd1), 8'($urandom));  // 0 - 1 wraps
    send_request({tfrce_pkg::OP_PRINT, 2'd2}, 8'($urandom));
    // 255 * 255 low byte
    send_request(alu_instr(tfrce_pkg::ALU_MUL, 2'd2, 2'd2), 8'($urandom));
    send_request({tfrce_pkg::OP_PRINT, 2'd2}, 8'($urandom));
    send_request({1'b0, 7'h7F}, 8'hFF);                          // largest move
    send_request({tfrce_pkg::OP_PRINT, 2'd3}, 8'($urandom));
    send_request(alu_instr(tfrce_pkg::ALU_DIV, 2'd3, 2'd1), 8'($urandom));  // divide by one
    send_request({tfrce_pkg::OP_LOAD, 2'd1}, 8'hFF);
    // 127 / 255 gives zero
    send_request(alu_instr(tfrce_pkg::ALU_DIV, 2'd3, 2'd1), 8'($urandom));
    send_request({tfrce_pkg::OP_PRINT, 2'd3}, 8'($urandom));
    send_request({1'b0, 7'h00}, 8'h00);                          // smallest move
    send_request({tfrce_pkg::OP_LOAD, 2'd0}, 8'hAA);
    send_request(alu_instr(tfrce_pkg::ALU_MUL, 2'd0, 2'd1), 8'($urandom));
    send_request(alu_instr(tfrce_pkg::ALU_SUB, 2'd1, 2'd0), 8'($urandom));
    send_request({tfrce_pkg::OP_PRINT, 2'd0}, 8'($urandom));
    send_request({tfrce_pkg::OP_PRINT, 2'd1}, 8'($urandom));
    // register by itself
    send_request(alu_instr(tfrce_pkg::ALU_DIV, 2'd1, 2'd1), 8'($urandom));
    send_request({tfrce_pkg::OP_PRINT, 2'd1}, 8'($urandom));
    send_request({tfrce_pkg::OP_PRINT, 2'd3}, 8'($urandom));
  endtask

  // random well-formed programs, first stretch without any idling
  task automatic test_random(input int count);
    logic [7:0] instr;
    no_idle <= 1'b1;
    for (int i = 0; i < count; i++) begin
      if (i == count / 5) no_idle <= 1'b0;
      instr = pick_instruction();
      send_request(instr, pick_value());
    end
  endtask

  // receiver holds off while requests keep coming, block must stall its input
  task automatic test_backpressure();
    logic [7:0] instr;
    no_idle <= 1'b1;
    fork
      begin
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
      end
    join_none
    for (int i = 0; i < 16; i++) begin
      instr = pick_instruction();
      send_request(instr, pick_value());
    end
    no_idle <= 1'b0;
  endtask

  // one halting error (the block stays halted for the rest of the run),
  // then arbitrary requests that must all come back quiet
  task automatic test_halt();
    logic [1:0] src;
    src = 2'($urandom);
    if ($urandom_range(0, 1) == 0) begin
      send_request(8'($urandom_range(8'hC8, 8'hFF)), 8'($urandom));  // undefined opcode
    end else begin
      send_request({tfrce_pkg::OP_LOAD, src}, 8'h00);
      // divide by zero
      send_request(alu_instr(tfrce_pkg::ALU_DIV, 2'($urandom), src), 8'($urandom));
    end
    send_request({tfrce_pkg::OP_PRINT, 2'd3}, 8'($urandom));
    for (int i = 0; i < 20; i++)
      send_request(8'($urandom), 8'($urandom));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(RANDOM_ITEMS);
    test_backpressure();
    test_halt();
    in_valid <= 1'b0;
    // drain, then allow for the slowest request
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
